### hw/rtl/rau_pkg.sv
// Shared constants and types for the rational arithmetic unit.
// Used by the controller, datapath and top level; depends on nothing.
package rau_pkg;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  // multiplier step: which cross product is formed
  localparam logic [1:0] MSTEP_P1 = 2'd0;
  localparam logic [1:0] MSTEP_P2 = 2'd1;
  localparam logic [1:0] MSTEP_P3 = 2'd2;

  // divider operand selection
  localparam logic [1:0] DSEL_GCD = 2'd0;
  localparam logic [1:0] DSEL_NUM = 2'd1;
  localparam logic [1:0] DSEL_DEN = 2'd2;

  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 32;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       comb;
    logic       gcd_load;
    logic       div_start;
    logic [1:0] div_sel;
    logic       out_load;
  } rau_cmd_t;

  typedef struct packed {
    logic nz;
    logic gy_zero;
    logic div_done;
    logic out_free;
  } rau_sts_t;

endpackage

### hw/rtl/rau_if.sv
// Handshake interfaces for the operand and result channels.
// Depend on nothing; result widths follow the fixed output fields.
interface rau_in_if #(parameter int OPERAND_WIDTH = 16);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      action;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic [OPERAND_WIDTH-1:0]        a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic [OPERAND_WIDTH-1:0]        b_den;

  modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] res_num;
  logic [31:0]        res_den;
  logic               is_zero;
  logic               is_negative;
  logic               is_positive;

  modport source (output valid, res_num, res_den, is_zero, is_negative, is_positive,
                  input ready);
  modport sink (input valid, res_num, res_den, is_zero, is_negative, is_positive,
                output ready);
endinterface

### hw/rtl/rau_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the datapath for remainders and exact quotients.
module rau_div #(
  parameter int N = 33
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [N-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quo,
  output logic [N-1:0] rem
);
  localparam int CW = $clog2(N + 1);

  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [N-1:0]  rem_r, rem_nxt;
  logic [N-1:0]  quo_r, quo_nxt;
  logic [N-1:0]  dsr_r;
  logic [N:0]    trial;
  logic [N:0]    diff;

  always_comb begin
    trial = {rem_r, quo_r[N-1]};
    diff  = trial - {1'b0, dsr_r};
    if (!diff[N]) begin
      rem_nxt = diff[N-1:0];
      quo_nxt = {quo_r[N-2:0], 1'b1};
    end else begin
      rem_nxt = trial[N-1:0];
      quo_nxt = {quo_r[N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CW'(1));
      if (start) begin
        cnt_r <= CW'(N);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule

### hw/rtl/rau_ctrl.sv
// Sequencer for the rational arithmetic unit.
// Depends on rau_pkg for the command and status structs.
module rau_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rau_pkg::rau_sts_t sts,
  output rau_pkg::rau_cmd_t cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL0 = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_COMB = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_GCD  = 4'd6;
  localparam logic [3:0] S_GWT  = 4'd7;
  localparam logic [3:0] S_QNUM = 4'd8;
  localparam logic [3:0] S_QNWT = 4'd9;
  localparam logic [3:0] S_QDEN = 4'd10;
  localparam logic [3:0] S_QDWT = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.mul_step = rau_pkg::MSTEP_P1;
    cmd.div_sel  = rau_pkg::DSEL_GCD;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = rau_pkg::MSTEP_P1;
        state_nxt    = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = rau_pkg::MSTEP_P2;
        state_nxt    = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = rau_pkg::MSTEP_P3;
        state_nxt    = S_COMB;
      end
      S_COMB: begin
        cmd.comb  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // a zero part leaves the fraction unreduced
        if (sts.nz) begin
          cmd.gcd_load = 1'b1;
          state_nxt    = S_GCD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_GCD: begin
        if (sts.gy_zero) begin
          state_nxt = S_QNUM;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_GWT;
        end
      end
      S_GWT: begin
        if (sts.div_done) state_nxt = S_GCD;
      end
      S_QNUM: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rau_pkg::DSEL_NUM;
        state_nxt     = S_QNWT;
      end
      S_QNWT: begin
        cmd.div_sel = rau_pkg::DSEL_NUM;
        if (sts.div_done) state_nxt = S_QDEN;
      end
      S_QDEN: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rau_pkg::DSEL_DEN;
        state_nxt     = S_QDWT;
      end
      S_QDWT: begin
        cmd.div_sel = rau_pkg::DSEL_DEN;
        if (sts.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

### hw/rtl/rau_dp.sv
// Datapath: shared multiplier, cross-product combine, Euclid registers,
// divider and output register. Depends on rau_pkg and rau_div.
module rau_dp #(
  parameter int W = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rau_pkg::rau_cmd_t                     cmd,
  output rau_pkg::rau_sts_t                     sts,
  input  logic [1:0]                            action,
  input  logic signed [W-1:0]                   a_num,
  input  logic [W-1:0]                          a_den,
  input  logic signed [W-1:0]                   b_num,
  input  logic [W-1:0]                          b_den,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rau_pkg::RES_NUM_W-1:0]  res_num,
  output logic [rau_pkg::RES_DEN_W-1:0]         res_den,
  output logic                                  is_zero,
  output logic                                  is_negative,
  output logic                                  is_positive
);
  localparam int MW = W + 1;
  localparam int PW = 2 * MW;
  localparam int NW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;

  logic [1:0]           act_r;
  logic signed [W-1:0]  an_r, bn_r;
  logic [W-1:0]         ad_r, bd_r;
  logic signed [MW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] p1_r, p2_r, p3_r;
  logic [NW-1:0]        p1n, p2n, p3n, num_c, den_c;
  logic                 neg_r;
  logic [NW-1:0]        mag_r, den_r, gx_r, gy_r;
  logic [NW-1:0]        dvd, dvs, quo, rem;
  logic                 div_done;
  logic signed [NW-1:0] num_o;
  logic                 out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action;
      an_r  <= a_num;
      ad_r  <= a_den;
      bn_r  <= b_num;
      bd_r  <= b_den;
    end
  end

  always_comb begin
    op_a = MW'(an_r);
    op_b = $signed({1'b0, bd_r});
    unique case (cmd.mul_step)
      rau_pkg::MSTEP_P1: begin
        op_a = MW'(an_r);
        op_b = (act_r == rau_pkg::ACT_MUL) ? MW'(bn_r) : $signed({1'b0, bd_r});
      end
      rau_pkg::MSTEP_P2: begin
        op_a = MW'(bn_r);
        op_b = $signed({1'b0, ad_r});
      end
      rau_pkg::MSTEP_P3: begin
        op_a = $signed({1'b0, ad_r});
        op_b = $signed({1'b0, bd_r});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod = op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      unique case (cmd.mul_step)
        rau_pkg::MSTEP_P1: p1_r <= prod;
        rau_pkg::MSTEP_P2: p2_r <= prod;
        default:           p3_r <= prod;
      endcase
    end
  end

  always_comb begin
    p1n = p1_r[NW-1:0];
    p2n = p2_r[NW-1:0];
    p3n = p3_r[NW-1:0];
    unique case (act_r)
      rau_pkg::ACT_ADD: begin
        num_c = p1n + p2n;
        den_c = p3n;
      end
      rau_pkg::ACT_SUB: begin
        num_c = p1n - p2n;
        den_c = p3n;
      end
      rau_pkg::ACT_MUL: begin
        num_c = p1n;
        den_c = p3n;
      end
      default: begin
        // move a negative denominator's sign onto the numerator
        num_c = p2_r[PW-1] ? NW'(0) - p1n : p1n;
        den_c = p2_r[PW-1] ? NW'(0) - p2n : p2n;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.div_sel)
      rau_pkg::DSEL_GCD: begin
        dvd = gx_r;
        dvs = gy_r;
      end
      rau_pkg::DSEL_NUM: begin
        dvd = mag_r;
        dvs = gx_r;
      end
      default: begin
        dvd = den_r;
        dvs = gx_r;
      end
    endcase
  end

  rau_div #(.N(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.comb) begin
      neg_r <= num_c[NW-1];
      mag_r <= num_c[NW-1] ? NW'(0) - num_c : num_c;
      den_r <= den_c;
    end else if (cmd.gcd_load) begin
      gx_r <= den_r;
      gy_r <= mag_r;
    end else if (div_done) begin
      unique case (cmd.div_sel)
        rau_pkg::DSEL_GCD: begin
          gx_r <= gy_r;
          gy_r <= rem;
        end
        rau_pkg::DSEL_NUM: mag_r <= quo;
        default:           den_r <= quo;
      endcase
    end
  end

  assign num_o = neg_r ? $signed(NW'(0) - mag_r) : $signed(mag_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_num     <= rau_pkg::RES_NUM_W'(num_o);
      res_den     <= rau_pkg::RES_DEN_W'(den_r);
      is_zero     <= (mag_r == '0);
      is_negative <= neg_r;
      is_positive <= !neg_r && (mag_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)            out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready)    out_valid_r <= 1'b0;
  end

  assign out_valid    = out_valid_r;
  assign sts.nz       = (mag_r != '0) && (den_r != '0);
  assign sts.gy_zero  = (gy_r == '0);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;
endmodule

### hw/rtl/rational_arith_unit.sv
// Rational arithmetic unit: adds, subtracts, multiplies or divides two
// fractions and reduces the result by its greatest common divisor.
//
// Channels: in_ch carries action, a_num, a_den, b_num, b_den; out_ch carries
// res_num, res_den and the zero/negative/positive flags. A transaction moves
// on a rising edge with valid and ready both high.
// One operation is in flight at a time; in_ch.ready is high while idle.
// Sequence: three multiplier steps (one shared (W+1)x(W+1) multiplier), combine
// and check, then when both parts are non-zero a Euclid loop of k remainder
// steps and two exact quotients, each a start state plus a pass of the
// bit-serial divider of N = 2W+1 bits, at most 64. The output register is
// then loaded and the sequencer returns to idle before the next accept.
// The divider sets the rate.
// The result waits in an output register; a stalled receiver holds it and
// the unit finishes the next operation up to the point of loading it.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output register.
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  rau_pkg::rau_cmd_t cmd;
  rau_pkg::rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rau_dp #(.W(OPERAND_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .action      (in_ch.action),
    .a_num       (in_ch.a_num),
    .a_den       (in_ch.a_den),
    .b_num       (in_ch.b_num),
    .b_den       (in_ch.b_den),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .res_num     (out_ch.res_num),
    .res_den     (out_ch.res_den),
    .is_zero     (out_ch.is_zero),
    .is_negative (out_ch.is_negative),
    .is_positive (out_ch.is_positive)
  );
endmodule

### bench/tb_rational_arith_unit.sv
// Self-checking bench for rational_arith_unit: random and directed fraction pairs,
// exact reduced results predicted locally. Depends on rau_pkg and rau_if (hw/rtl).
module tb_rational_arith_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] a_num;
    logic [15:0]        a_den;
    logic signed [15:0] b_num;
    logic [15:0]        b_den;
  } operands_t;

  typedef struct packed {
    logic signed [32:0] res_num;
    logic [31:0]        res_den;
    logic               is_zero;
    logic               is_negative;
    logic               is_positive;
  } fraction_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  rau_in_if #(.OPERAND_WIDTH(16)) in_ch ();
  rau_out_if out_ch ();

  rational_arith_unit #(.OPERAND_WIDTH(16)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  operands_t pending_ops[$];
  fraction_t expected_fracs[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  bit        rx_stall = 1'b0;

  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic fraction_t reduce_fraction(operands_t op);
    longint an, ad, bn, bd, num, den;
    longint unsigned mag, g;
    fraction_t f;
    an = op.a_num; ad = op.a_den; bn = op.b_num; bd = op.b_den;
    case (op.action)
      rau_pkg::ACT_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
      rau_pkg::ACT_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
      rau_pkg::ACT_MUL: begin num = an * bn; den = ad * bd; end
      default: begin
        num = an * bd;
        den = ad * bn;
        if (den < 0) begin
          den = -den;
          num = -num;
        end
      end
    endcase
    if (num != 0 && den != 0) begin
      mag = (num < 0) ? -num : num;
      g = euclid_gcd(den, mag);
      if (g > 1) begin
        mag = mag / g;
        den = den / g;
        num = (num < 0) ? -longint'(mag) : longint'(mag);
      end
    end
    f.res_num = num[32:0];
    f.res_den = den[31:0];
    f.is_zero = (num == 0);
    f.is_negative = (num < 0);
    f.is_positive = (num > 0);
    return f;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("error: %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic push_op(logic [1:0] act, logic [15:0] an, logic [15:0] ad,
                         logic [15:0] bn, logic [15:0] bd);
    operands_t op;
    op.action = act; op.a_num = an; op.a_den = ad; op.b_num = bn; op.b_den = bd;
    pending_ops.push_back(op);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return 16'hFFFF;
      4: return 16'($urandom_range(0, 12));
      default: return 16'($urandom);
    endcase
  endfunction

  // handshakes sampled on the rising edge
  bit in_fire;
  bit out_fire;
  always @(posedge clk) in_fire <= in_ch.valid && in_ch.ready;
  always @(posedge clk) out_fire <= out_ch.valid && out_ch.ready;

  // driver
  int send_gap = 0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = '0; in_ch.a_num = '0; in_ch.a_den = '0;
    in_ch.b_num = '0; in_ch.b_den = '0;
  end
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) begin
        expected_fracs.push_back(reduce_fraction(pending_ops.pop_front()));
        send_gap = $urandom_range(0, 11);
      end
      if (in_ch.valid && !in_fire) begin
        // hold offered transaction
      end else if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        in_ch.valid <= 1'b1;
        {in_ch.action, in_ch.a_num, in_ch.a_den, in_ch.b_num, in_ch.b_den} <= pending_ops[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver stall while the sender keeps offering
  initial begin
    @(posedge rst_n);
    repeat (60) @(posedge clk);
    rx_stall = 1'b1;
    repeat (400) @(posedge clk);
    rx_stall = 1'b0;
  end

  // receiver: random ready gaps
  int recv_gap = 0;
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_stall) begin
        out_ch.ready <= 1'b0;
      end else if (out_fire) begin
        recv_gap = $urandom_range(0, 11);
        if (recv_gap == 0) out_ch.ready <= 1'b1;
        else out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= (recv_gap == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    fraction_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_fracs.size() == 0) begin
        report_mismatch("unexpected res_num", out_ch.res_num, 0);
      end else begin
        want = expected_fracs.pop_front();
        if (out_ch.res_num !== want.res_num)
          report_mismatch("res_num", out_ch.res_num, want.res_num);
        if (out_ch.res_den !== want.res_den)
          report_mismatch("res_den", out_ch.res_den, want.res_den);
        if (out_ch.is_zero !== want.is_zero)
          report_mismatch("is_zero", out_ch.is_zero, want.is_zero);
        if (out_ch.is_negative !== want.is_negative)
          report_mismatch("is_negative", out_ch.is_negative, want.is_negative);
        if (out_ch.is_positive !== want.is_positive)
          report_mismatch("is_positive", out_ch.is_positive, want.is_positive);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 20000000) begin
      $display("rational_arith_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int tail;
    logic [1:0] act;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    for (int a = 0; a < 4; a++) begin
      act = a[1:0];
      push_op(act, 16'd3, 16'd4, 16'd5, 16'd6);
      push_op(act, 16'h8000, 16'hFFFF, 16'h8000, 16'hFFFF);
      push_op(act, 16'h7FFF, 16'hFFFF, 16'h8000, 16'd1);
      push_op(act, 16'd0, 16'd7, 16'd2, 16'd7);
      push_op(act, 16'd5, 16'd0, 16'hFFFD, 16'd3);
    end
    push_op(rau_pkg::ACT_DIV, 16'd4, 16'd9, 16'd0, 16'd5);
    push_op(rau_pkg::ACT_DIV, 16'd4, 16'd9, 16'hFFFE, 16'd3);
    push_op(rau_pkg::ACT_MUL, 16'd6, 16'd8, 16'd4, 16'd3);
    for (int i = 0; i < 1300; i++) begin
      act = 2'($urandom_range(0, 3));
      push_op(act, rand_field(), rand_field(), rand_field(), rand_field());
    end
    while (pending_ops.size() > 0 || expected_fracs.size() > 0 || in_ch.valid)
      @(posedge clk);
    tail = 0;
    while (tail < 300) begin
      @(posedge clk);
      tail++;
    end
    if (mismatches == 0 && expected_fracs.size() == 0)
      $display("rational_arith_unit: match");
    else
      $display("rational_arith_unit: mismatch");
    $finish;
  end
endmodule
